// File: sv/ecf_pkg.sv
package ecf_pkg;

    localparam logic [63:0] HASH_MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [63:0] HASH_MUL_B = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned HASH_SHIFT = 33;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SLOT_RD,
        ST_SLOT_CHK,
        ST_ID_CHK,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_tbl_stat;

    typedef struct packed {
        logic start;
        logic cmd;
    } t_tbl_ctrl;

endpackage

// File: sv/ecf_hash.sv
module ecf_hash #(
    parameter int HW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_key,
    output logic          o_done,
    output logic [HW-1:0] o_home
);
    import ecf_pkg::*;

    logic [63:0]   r_x;
    logic [63:0]   r_acc;
    logic [1:0]    r_ph;
    logic          r_rnd;
    logic          r_run;
    logic          r_done;
    logic [HW-1:0] r_home;
    logic [63:0]   mul_b;
    logic [31:0]   op_a;
    logic [31:0]   op_b;
    logic [63:0]   prod;
    logic [63:0]   sum_hi;
    logic [63:0]   mixed;

    assign mul_b  = r_rnd ? HASH_MUL_B : HASH_MUL_A;
    assign op_a   = (r_ph == 2'd1) ? r_x[63:32] : r_x[31:0];
    assign op_b   = (r_ph == 2'd2) ? mul_b[63:32] : mul_b[31:0];
    assign prod   = {32'b0, op_a} * {32'b0, op_b};
    assign sum_hi = r_acc + {prod[31:0], 32'b0};
    assign mixed  = sum_hi ^ (sum_hi >> HASH_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 2'd0;
            r_rnd  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x   <= i_key ^ (i_key >> HASH_SHIFT);
                r_run <= 1'b1;
                r_ph  <= 2'd0;
                r_rnd <= 1'b0;
            end else if (r_run) begin
                case (r_ph)
                    2'd0: begin
                        r_acc <= prod;
                        r_ph  <= 2'd1;
                    end
                    2'd1: begin
                        r_acc <= sum_hi;
                        r_ph  <= 2'd2;
                    end
                    default: begin
                        r_x  <= mixed;
                        r_ph <= 2'd0;
                        if (r_rnd) begin
                            r_run  <= 1'b0;
                            r_done <= 1'b1;
                            r_home <= mixed[HW-1:0];
                        end
                        r_rnd <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_home = r_home;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("hash done held");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> !i_start) else $error("hash restarted while running");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_run) else $error("hash done while running");
`endif
endmodule

// File: sv/ecf_table.sv
module ecf_table #(
    parameter int CAPACITY   = 4096,
    parameter int HASH_SLOTS = 8192,
    parameter int SW         = 12,
    parameter int CW         = 13,
    parameter int HW         = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ecf_pkg::t_tbl_ctrl    i_ctrl,
    input  logic [63:0]           i_src_id,
    input  logic [63:0]           i_trg_id,
    input  logic [SW-1:0]         i_read_index,
    output ecf_pkg::t_tbl_stat    o_stat,
    output logic [SW-1:0]         o_seq_src,
    output logic [SW-1:0]         o_seq_trg,
    output logic                  o_full,
    output logic [63:0]           o_raw_id,
    output logic [CW-1:0]         o_id_count
);
    import ecf_pkg::*;

    logic [SW:0]   slot_mem [HASH_SLOTS];
    logic [63:0]   id_mem   [CAPACITY];

    t_state        r_state;
    t_state        n_state;
    logic [HW-1:0] r_pos;
    logic [HW-1:0] r_n;
    logic [CW-1:0] r_next;
    logic [63:0]   r_key;
    logic [63:0]   r_trg;
    logic          r_k;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_seq_src;
    logic [SW-1:0] r_seq_trg;
    logic [SW-1:0] r_cand;
    logic          r_full;
    logic [63:0]   r_orig;
    logic [SW:0]   r_slot_q;
    logic [63:0]   r_id_q;

    logic          h_start;
    logic [63:0]   h_key;
    logic          h_done;
    logic [HW-1:0] h_home;

    logic          cap_full;
    logic          slot_re;
    logic          slot_we;
    logic [SW:0]   slot_wdata;
    logic          id_re;
    logic          id_we;
    logic [SW-1:0] id_raddr;
    logic          key_done;
    logic          key_full;
    logic [SW-1:0] key_seq;
    logic          probe_next;
    logic          accept;

    ecf_hash #(.HW(HW)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (h_start),
        .i_key   (h_key),
        .o_done  (h_done),
        .o_home  (h_home)
    );

    assign cap_full = (r_next == CW'(CAPACITY));
    assign accept   = (r_state == ST_IDLE) && i_ctrl.start;

    always_comb begin
        slot_re    = 1'b0;
        slot_we    = 1'b0;
        slot_wdata = '0;
        id_re      = 1'b0;
        id_we      = 1'b0;
        id_raddr   = r_slot_q[SW-1:0];
        key_done   = 1'b0;
        key_full   = 1'b0;
        key_seq    = '0;
        probe_next = 1'b0;
        h_start    = 1'b0;
        h_key      = r_trg;
        case (r_state)
            ST_CLEAR: begin
                slot_we = 1'b1;
            end
            ST_IDLE: begin
                if (i_ctrl.start && i_ctrl.cmd == CMD_READ) begin
                    id_re    = 1'b1;
                    id_raddr = i_read_index;
                end else if (i_ctrl.start) begin
                    h_start = 1'b1;
                    h_key   = i_src_id;
                end
            end
            ST_SLOT_RD: begin
                slot_re = 1'b1;
            end
            ST_SLOT_CHK: begin
                if (!r_slot_q[SW]) begin
                    key_done = 1'b1;
                    if (cap_full) begin
                        key_full = 1'b1;
                    end else begin
                        slot_we    = 1'b1;
                        slot_wdata = {1'b1, r_next[SW-1:0]};
                        id_we      = 1'b1;
                        key_seq    = r_next[SW-1:0];
                    end
                end else begin
                    id_re = 1'b1;
                end
            end
            ST_ID_CHK: begin
                if (r_id_q == r_key) begin
                    key_done = 1'b1;
                    key_seq  = r_cand;
                end else if (r_n == HW'(HASH_SLOTS - 1)) begin
                    key_done = 1'b1;
                    key_full = 1'b1;
                end else begin
                    probe_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (key_done && !r_k) begin
            h_start = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:    n_state = (r_pos == HW'(HASH_SLOTS - 1)) ? ST_IDLE : ST_CLEAR;
            ST_IDLE: begin
                if (i_ctrl.start) begin
                    n_state = (i_ctrl.cmd == CMD_READ) ? ST_RD_WAIT : ST_HASH;
                end
            end
            ST_HASH:     n_state = h_done ? ST_SLOT_RD : ST_HASH;
            ST_SLOT_RD:  n_state = ST_SLOT_CHK;
            ST_SLOT_CHK: begin
                if (key_done) begin
                    n_state = r_k ? ST_DONE : ST_HASH;
                end else begin
                    n_state = ST_ID_CHK;
                end
            end
            ST_ID_CHK: begin
                if (key_done) begin
                    n_state = r_k ? ST_DONE : ST_HASH;
                end else begin
                    n_state = ST_SLOT_RD;
                end
            end
            ST_RD_WAIT:  n_state = ST_DONE;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_pos   <= '0;
            r_next  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_pos <= r_pos + 1'b1;
            end else if (r_state == ST_HASH && h_done) begin
                r_pos <= h_home;
            end else if (probe_next) begin
                r_pos <= r_pos + 1'b1;
            end
            if (id_we) begin
                r_next <= r_next + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key     <= i_src_id;
            r_trg     <= i_trg_id;
            r_idx     <= i_read_index;
            r_k       <= 1'b0;
            r_full    <= 1'b0;
            r_seq_src <= '0;
            r_seq_trg <= '0;
            r_orig    <= '0;
        end
        if (r_state == ST_HASH && h_done) begin
            r_n <= '0;
        end else if (probe_next) begin
            r_n <= r_n + 1'b1;
        end
        if (r_state == ST_SLOT_CHK) begin
            r_cand <= r_slot_q[SW-1:0];
        end
        if (key_done) begin
            r_full <= r_full | key_full;
            if (!r_k) begin
                r_seq_src <= key_seq;
                r_k       <= 1'b1;
                r_key     <= r_trg;
            end else begin
                r_seq_trg <= key_seq;
            end
        end
        if (r_state == ST_RD_WAIT) begin
            r_orig <= (CW'(r_idx) < r_next) ? r_id_q : 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[r_pos] <= slot_wdata;
        end
        if (slot_re) begin
            r_slot_q <= slot_mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (id_we) begin
            id_mem[r_next[SW-1:0]] <= r_key;
        end
        if (id_re) begin
            r_id_q <= id_mem[id_raddr];
        end
    end

    assign o_stat.busy   = (r_state != ST_IDLE);
    assign o_stat.done   = (r_state == ST_DONE);
    assign o_seq_src     = r_seq_src;
    assign o_seq_trg     = r_seq_trg;
    assign o_full        = r_full;
    assign o_raw_id      = r_orig;
    assign o_id_count    = r_next;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= CW'(CAPACITY)) else $error("id count beyond capacity");
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        id_we |-> !cap_full && slot_we) else $error("insert without room");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |=> r_state == ST_IDLE) else $error("done not followed by idle");
    a_hash_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_done |-> r_state == ST_HASH) else $error("hash result unexpected");
`endif
endmodule

// File: sv/edge_id_compactor_time_filter_unit.sv
// channel  | direction | handshake              | payload
// cmd      | in        | start & !busy          | i_cmd, i_src_id, i_trg_id, i_time_*, i_read_index
// result   | out       | o_strobe, one cycle    | o_seq_src, o_seq_trg, o_keep, o_full_res, ...
// config   | in        | i_cfg_valid & o_cfg_ready | i_cfg_data (snapshot time)
//
// Edge: two hash evaluations (shared 32x32 multiplier, 3 passes per 64-bit product),
// then per probe a slot memory read and check (ST_SLOT_RD, ST_SLOT_CHK) plus an id
// memory compare (ST_ID_CHK) per occupied slot. The result strobes in the cycle after
// ST_DONE. Read command: id memory read on acceptance, word registered in ST_RD_WAIT.
// After reset the slot memory is swept clear with busy high.
// The receiver cannot stall; a new command may start during the result strobe.
module edge_id_compactor_time_filter_unit #(
    parameter int CAPACITY   = 4096,
    parameter int HASH_SLOTS = 8192,
    localparam int SW        = $clog2(CAPACITY),
    localparam int CW        = $clog2(CAPACITY + 1),
    localparam int HW        = $clog2(HASH_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          i_cmd,
    input  logic [63:0]   i_src_id,
    input  logic [63:0]   i_trg_id,
    input  logic [31:0]   i_time_added,
    input  logic [31:0]   i_time_deleted,
    input  logic [SW-1:0] i_read_index,
    output logic          o_strobe,
    output logic [SW-1:0] o_seq_src,
    output logic [SW-1:0] o_seq_trg,
    output logic          o_keep,
    output logic          o_full_res,
    output logic [63:0]   o_raw_id,
    output logic [CW-1:0] o_id_count,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [31:0]   i_cfg_data
);
    import ecf_pkg::*;

    logic [31:0]   r_snap_time;
    logic          r_keep;
    logic          r_strobe;
    logic [SW-1:0] r_seq_src;
    logic [SW-1:0] r_seq_trg;
    logic          r_keep_out;
    logic          r_full_out;
    logic [63:0]   r_orig_out;
    logic [CW-1:0] r_cnt_out;

    t_tbl_ctrl     tbl_ctrl;
    t_tbl_stat     tbl_stat;
    logic [SW-1:0] t_seq_src;
    logic [SW-1:0] t_seq_trg;
    logic          t_full;
    logic [63:0]   t_orig;
    logic [CW-1:0] t_cnt;
    logic          accept;
    logic          keep_now;

    assign accept         = start && !tbl_stat.busy;
    assign tbl_ctrl.start = start;
    assign tbl_ctrl.cmd   = i_cmd;
    assign keep_now = (i_cmd == CMD_EDGE) &&
                      ((r_snap_time == 32'd0) ||
                       ((i_time_added <= r_snap_time) &&
                        ((r_snap_time <= i_time_deleted) || (i_time_deleted == 32'd0))));

    ecf_table #(
        .CAPACITY   (CAPACITY),
        .HASH_SLOTS (HASH_SLOTS),
        .SW         (SW),
        .CW         (CW),
        .HW         (HW)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (tbl_ctrl),
        .i_src_id      (i_src_id),
        .i_trg_id      (i_trg_id),
        .i_read_index  (i_read_index),
        .o_stat        (tbl_stat),
        .o_seq_src     (t_seq_src),
        .o_seq_trg     (t_seq_trg),
        .o_full        (t_full),
        .o_raw_id      (t_orig),
        .o_id_count    (t_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_time <= 32'd0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_snap_time <= i_cfg_data;
            end
            r_strobe <= tbl_stat.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_keep <= keep_now;
        end
        if (tbl_stat.done) begin
            r_seq_src  <= t_seq_src;
            r_seq_trg  <= t_seq_trg;
            r_keep_out <= r_keep;
            r_full_out <= t_full;
            r_orig_out <= t_orig;
            r_cnt_out  <= t_cnt;
        end
    end

    assign busy          = tbl_stat.busy;
    assign o_cfg_ready   = 1'b1;
    assign o_strobe      = r_strobe;
    assign o_seq_src     = r_seq_src;
    assign o_seq_trg     = r_seq_trg;
    assign o_keep        = r_keep_out;
    assign o_full_res    = r_full_out;
    assign o_raw_id      = r_orig_out;
    assign o_id_count    = r_cnt_out;

`ifndef SYNTHESIS
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("result strobe held");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_stat.done |=> o_strobe) else $error("result beat lost");
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_raw_id != 64'd0 |-> !o_keep && !o_full_res)
        else $error("read beat carries edge flags");
`endif
endmodule

// File: tb/sv/edge_id_compactor_time_filter_unit_test.sv
module edge_id_compactor_time_filter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ecf_pkg::*;

    localparam int CAP      = 4096;
    localparam int SLOTS    = 8192;
    localparam int N_RANDOM = 1730;
    localparam int WD_LIMIT = 40000;
    localparam int SETTLE   = 60;

    typedef struct packed {
        logic [11:0] seq_src;
        logic [11:0] seq_trg;
        logic        keep;
        logic        full;
        logic [63:0] orig;
        logic [12:0] count;
    } t_res;

    typedef struct packed {
        logic        cmd;
        logic [63:0] src;
        logic [63:0] trg;
        logic [31:0] t_add;
        logic [31:0] t_del;
        logic [11:0] idx;
    } t_item;

    typedef struct packed {
        logic        is_cfg;
        logic [31:0] cfg_val;
        t_item       item;
        logic        typed;
        t_res        res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cmd = CMD_EDGE;
    logic [63:0] i_src_id = '0;
    logic [63:0] i_trg_id = '0;
    logic [31:0] i_time_added = '0;
    logic [31:0] i_time_deleted = '0;
    logic [11:0] i_read_index = '0;
    logic        o_strobe;
    logic [11:0] o_seq_src;
    logic [11:0] o_seq_trg;
    logic        o_keep;
    logic        o_full_res;
    logic [63:0] o_raw_id;
    logic [12:0] o_id_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    edge_id_compactor_time_filter_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // mirror of the id map
    bit          slot_used [SLOTS];
    logic [11:0] slot_seq  [SLOTS];
    logic [63:0] id_mem    [CAP];
    int unsigned id_total;
    logic [31:0] snap_time;

    t_res pending_results[$];
    int   errors;
    int   n_items, n_results, n_full, n_reads, n_keep;
    int   idle_cycles;

    function automatic logic [12:0] slot_home(logic [63:0] key);
        logic [63:0] x;
        x = key;
        x = x ^ (x >> HASH_SHIFT);
        x = x * HASH_MUL_A;
        x = x ^ (x >> HASH_SHIFT);
        x = x * HASH_MUL_B;
        x = x ^ (x >> HASH_SHIFT);
        return x[12:0];
    endfunction

    function automatic logic [11:0] idmap_lookup(logic [63:0] key, ref logic full);
        int unsigned pos;
        pos = 32'(slot_home(key));
        for (int n = 0; n < SLOTS; n++) begin
            if (!slot_used[pos]) begin
                if (id_total >= CAP) begin
                    full = 1'b1;
                    return '0;
                end
                slot_used[pos] = 1'b1;
                slot_seq[pos] = id_total[11:0];
                id_mem[id_total] = key;
                id_total++;
                return slot_seq[pos];
            end
            if (id_mem[slot_seq[pos]] == key) return slot_seq[pos];
            pos = (pos + 1) % SLOTS;
        end
        full = 1'b1;
        return '0;
    endfunction

    function automatic t_res predict_result(t_item it);
        t_res r;
        logic full;
        r = '0;
        full = 1'b0;
        if (it.cmd == CMD_READ) begin
            if (it.idx < id_total) r.orig = id_mem[it.idx];
        end else begin
            r.seq_src = idmap_lookup(it.src, full);
            r.seq_trg = idmap_lookup(it.trg, full);
            r.full = full;
            r.keep = (snap_time == 0) ||
                     (it.t_add <= snap_time && (snap_time <= it.t_del || it.t_del == 0));
        end
        r.count = id_total[12:0];
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (o_strobe) begin
            t_res w;
            n_results++;
            if (pending_results.size() == 0) begin
                report("unexpected beat", o_id_count, 0);
            end else begin
                w = pending_results.pop_front();
                if (o_seq_src !== w.seq_src) report("seq_src", o_seq_src, w.seq_src);
                if (o_seq_trg !== w.seq_trg) report("seq_trg", o_seq_trg, w.seq_trg);
                if (o_keep !== w.keep) report("keep", o_keep, w.keep);
                if (o_full_res !== w.full) report("full_res", o_full_res, w.full);
                if (o_raw_id !== w.orig) report("raw_id", o_raw_id, w.orig);
                if (o_id_count !== w.count) report("id_count", o_id_count, w.count);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (o_strobe || (start && !busy) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("timeout after %0d quiet cycles", WD_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // send one command; returns at the edge that accepts it
    task automatic send_item(t_item it, logic typed, t_res typed_res);
        t_res p;
        start          <= 1'b1;
        i_cmd          <= it.cmd;
        i_src_id       <= it.src;
        i_trg_id       <= it.trg;
        i_time_added   <= it.t_add;
        i_time_deleted <= it.t_del;
        i_read_index   <= it.idx;
        do @(posedge i_clk); while (busy);
        p = predict_result(it);
        pending_results.insert(pending_results.size(), typed ? typed_res : p);
        n_items++;
        if (it.cmd == CMD_READ) n_reads++;
        if (p.full) n_full++;
        if (p.keep) n_keep++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_snap(logic [31:0] v);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        snap_time = v;
    endtask

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [63:0] pick_id(logic [63:0] other);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 || id_total == 0) return {$urandom, $urandom};
        if (r < 85) return id_mem[$urandom_range(0, id_total - 1)];
        if (r < 90) return 64'h0;
        if (r < 95) return '1;
        return other;
    endfunction

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return snap_time;
            2: return snap_time + 1;
            3: return snap_time - 1;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item rand_item(bit fresh_only);
        t_item it;
        it.cmd   = ($urandom_range(0, 9) == 0 && !fresh_only) ? CMD_READ : CMD_EDGE;
        it.src   = fresh_only ? {$urandom, $urandom} : pick_id(64'h0);
        it.trg   = fresh_only ? {$urandom, $urandom} : pick_id(it.src);
        it.t_add = pick_time();
        it.t_del = pick_time();
        if (id_total > 0 && $urandom_range(0, 3) != 0)
            it.idx = 12'($urandom_range(0, id_total - 1));
        else
            it.idx = 12'($urandom);
        return it;
    endfunction

    function automatic t_row mk(logic is_cfg, logic [31:0] cv, logic cmd, logic [63:0] s,
                                logic [63:0] t, logic [31:0] ta, logic [31:0] td,
                                logic [11:0] ix, logic typed, t_res r);
        t_row row;
        row.is_cfg = is_cfg;
        row.cfg_val = cv;
        row.item = '{cmd, s, t, ta, td, ix};
        row.typed = typed;
        row.res = r;
        return row;
    endfunction

    t_row stim_table[$];

    function automatic void add_row(t_row row);
        stim_table.insert(stim_table.size(), row);
    endfunction

    initial begin
        t_res  none;
        t_item it;
        bit    burst;
        none = '0;
        errors = 0;
        id_total = 0;
        snap_time = '0;
        idle_cycles = 0;

        // typed rows carry their expected results written out by hand; the rest go through the predictor
        add_row(mk(1, 32'h0, 0, 0, 0, 0, 0, 0, 0, none));
        add_row(mk(0, 0, CMD_EDGE, 64'h0, 64'h0, 32'h5, 32'h0, 12'h0, 1,
                   '{12'd0, 12'd0, 1'b1, 1'b0, 64'h0, 13'd1}));
        add_row(mk(0, 0, CMD_EDGE, '1, 64'h1, '1, '1, '1, 1,
                   '{12'd1, 12'd2, 1'b1, 1'b0, 64'h0, 13'd3}));
        add_row(mk(0, 0, CMD_READ, '1, '1, '1, '1, 12'd1, 1,
                   '{12'd0, 12'd0, 1'b0, 1'b0, '1, 13'd3}));
        add_row(mk(0, 0, CMD_READ, 0, 0, 0, 0, 12'd0, 1,
                   '{12'd0, 12'd0, 1'b0, 1'b0, 64'h0, 13'd3}));
        add_row(mk(0, 0, CMD_READ, 0, 0, 0, 0, 12'hFFF, 1,
                   '{12'd0, 12'd0, 1'b0, 1'b0, 64'h0, 13'd3}));
        add_row(mk(0, 0, CMD_EDGE, 64'h1, 64'h0, 0, 0, 0, 1,
                   '{12'd2, 12'd0, 1'b1, 1'b0, 64'h0, 13'd3}));
        add_row(mk(0, 0, CMD_EDGE, {4{16'hA5A5}}, {4{16'hA5A5}}, 0, 0, 0, 1,
                   '{12'd3, 12'd3, 1'b1, 1'b0, 64'h0, 13'd4}));
        add_row(mk(0, 0, CMD_READ, 0, 0, 0, 0, 12'd3, 1,
                   '{12'd0, 12'd0, 1'b0, 1'b0, {4{16'hA5A5}}, 13'd4}));
        add_row(mk(1, 32'd100, 0, 0, 0, 0, 0, 0, 0, none));
        add_row(mk(0, 0, CMD_EDGE, 64'h1, 64'h2, 32'd100, 32'd0, 0, 0, none));
        add_row(mk(0, 0, CMD_EDGE, 64'h3, 64'h2, 32'd101, 32'd0, 0, 0, none));
        add_row(mk(0, 0, CMD_EDGE, 64'h3, 64'h4, 32'd100, 32'd99, 0, 0, none));
        add_row(mk(0, 0, CMD_EDGE, 64'h4, 64'h1, 32'd99, 32'd100, 0, 0, none));
        add_row(mk(0, 0, CMD_EDGE, {32'h5A5A5A5A, 32'h0}, 64'h0, 32'd0, '1, 0, 0,
                   none));
        add_row(mk(0, 0, CMD_READ, '1, '1, '1, '1, 12'd5, 0, none));
        add_row(mk(1, '1, 0, 0, 0, 0, 0, 0, 0, none));
        add_row(mk(0, 0, CMD_EDGE, 64'h7, 64'h8, '1, 32'd0, 0, 0, none));
        add_row(mk(0, 0, CMD_EDGE, 64'h8, 64'h7, '1, 32'hFFFF_FFFE, 0, 0, none));
        add_row(mk(0, 0, CMD_EDGE, 64'h9, 64'h9, '1, '1, 0, 0, none));
        add_row(mk(1, 32'd1, 0, 0, 0, 0, 0, 0, 0, none));
        add_row(mk(0, 0, CMD_EDGE, 64'h9, 64'h1, 32'd1, 32'd1, 0, 0, none));
        add_row(mk(0, 0, CMD_EDGE, 64'h9, 64'h1, 32'd2, 32'd0, 0, 0, none));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg) begin
                write_snap(stim_table[i].cfg_val);
            end else begin
                send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].res);
                idle_gap(pick_gap(1'b0));
            end
        end

        burst = 1'b0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 350 == 349) begin
                case ((i / 350) % 4)
                    0: write_snap(32'h0);
                    1: write_snap('1);
                    2: write_snap($urandom_range(1, 1000));
                    default: write_snap($urandom);
                endcase
            end
            if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
            if (i == 900) drain();
            send_item(rand_item(1'b0), 1'b0, none);
            idle_gap(pick_gap(burst));
        end

        it = rand_item(1'b0);
        it.cmd = CMD_READ;
        it.idx = 12'hFFF;
        send_item(it, 1'b0, none);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        $display("%0d commands (%0d reads), %0d results, %0d ids mapped",
                 n_items, n_reads, n_results, id_total);
        $display("%0d edges kept by the time filter, %0d hit a full map", n_keep, n_full);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: edge_id_compactor_time_filter_unit.f
sv/ecf_pkg.sv
sv/ecf_hash.sv
sv/ecf_table.sv
sv/edge_id_compactor_time_filter_unit.sv
tb/sv/edge_id_compactor_time_filter_unit_test.sv
